// ===== rtl/evr_pkg.sv =====
// Shared types and constants of the energy voice activity recorder.
`default_nettype none
package evr_pkg;

   // operation codes carried by req_op
   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_START   = 2'd1;
   localparam logic [1:0] OP_STOP    = 2'd2;
   localparam logic [1:0] OP_DISCARD = 2'd3;

   // register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_NEEDED    = 2'd1;
   localparam logic [1:0] REG_CAPACITY  = 2'd2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int SAMPLE_W = 16;
   localparam int LEN_W    = 18;
   localparam int SUM_W    = 24;
   localparam int CNT_W    = 9;
   localparam int SILENT_W = 16;

   localparam logic [CNT_W-1:0] FRAME_SAMPLES = 9'd480;

   localparam logic [15:0]      THRESHOLD_RST = 16'd200;
   localparam logic [15:0]      NEEDED_RST    = 16'd30;
   localparam logic [LEN_W-1:0] CAPACITY_RST  = 18'd192000;

   typedef struct packed {
      logic [15:0]      silence_threshold;
      logic [15:0]      silent_frames_needed;
      logic [LEN_W-1:0] record_capacity;
   } evr_cfg_type;

   typedef struct packed {
      logic             is_recording;
      logic             silence_detected;
      logic [LEN_W-1:0] recorded_samples;
      logic             frame_was_silent;
   } evr_result_type;

endpackage
`default_nettype wire

// ===== rtl/evr_csr.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none
module evr_csr
   import evr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output evr_cfg_type                cfg
);

   evr_cfg_type cfg_ff, cfg_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_THRESHOLD: cfg_in.silence_threshold    = csr_pwdata[15:0];
            REG_NEEDED:    cfg_in.silent_frames_needed = csr_pwdata[15:0];
            REG_CAPACITY:  cfg_in.record_capacity      = csr_pwdata[LEN_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_THRESHOLD: csr_prdata = {16'd0, cfg_ff.silence_threshold};
         REG_NEEDED:    csr_prdata = {16'd0, cfg_ff.silent_frames_needed};
         REG_CAPACITY:  csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, cfg_ff.record_capacity};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.silence_threshold    <= THRESHOLD_RST;
         cfg_ff.silent_frames_needed <= NEEDED_RST;
         cfg_ff.record_capacity      <= CAPACITY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/evr_core.sv =====
// Recorder state and combinational next-state frame energy update.
`default_nettype none
module evr_core
   import evr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [1:0]          op,
   input  wire logic [SAMPLE_W-1:0] sample,
   input  wire logic                frame_end,
   input  wire evr_cfg_type         cfg,
   output evr_result_type           result
);

   logic                recording_ff, recording_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SILENT_W-1:0] silent_ff, silent_in;

   logic [SAMPLE_W-1:0] mag;
   logic [SUM_W-1:0]    sum_add;
   logic [CNT_W-1:0]    cnt_add;
   logic                close;
   logic [LEN_W:0]      len_total;
   logic                overflow;
   logic [SUM_W:0]      limit;
   logic                quiet;
   logic                was_silent;

   // |sample|; -32768 maps to 0x8000
   assign mag       = sample[SAMPLE_W-1] ? SAMPLE_W'(~sample + 1'b1) : sample;
   assign sum_add   = sum_ff + SUM_W'(mag);
   assign cnt_add   = cnt_ff + 1'b1;
   assign close     = frame_end || (cnt_add >= FRAME_SAMPLES);
   assign len_total = {1'b0, len_ff} + (LEN_W+1)'(cnt_add);
   assign overflow  = len_total > {1'b0, cfg.record_capacity};
   // threshold * count, 16 x 9 bits
   assign limit     = (SUM_W+1)'(cfg.silence_threshold * cnt_add);
   assign quiet     = {1'b0, sum_add} < limit;

   always_comb begin
      recording_in = recording_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      silent_in    = silent_ff;
      was_silent   = 1'b0;
      case (op)
         OP_START: begin
            recording_in = 1'b1;
            len_in       = '0;
            silent_in    = '0;
            sum_in       = '0;
            cnt_in       = '0;
         end
         OP_STOP: begin
            recording_in = 1'b0;
            sum_in       = '0;
            cnt_in       = '0;
         end
         OP_DISCARD: begin
            recording_in = 1'b0;
            len_in       = '0;
            sum_in       = '0;
            cnt_in       = '0;
         end
         OP_SAMPLE: begin
            if (recording_ff) begin
               sum_in = sum_add;
               cnt_in = cnt_add;
               if (close) begin
                  sum_in = '0;
                  cnt_in = '0;
                  if (overflow) begin
                     recording_in = 1'b0;
                  end else begin
                     len_in = len_total[LEN_W-1:0];
                     if (quiet) begin
                        was_silent = 1'b1;
                        if (silent_ff != '1) silent_in = silent_ff + 1'b1;
                     end else begin
                        silent_in = '0;
                     end
                  end
               end
            end
         end
         default: recording_in = recording_ff;
      endcase
   end

   assign result.is_recording     = recording_in;
   assign result.silence_detected = recording_in && (silent_in >= cfg.silent_frames_needed);
   assign result.recorded_samples = len_in;
   assign result.frame_was_silent = was_silent;

   always_ff @(posedge clock) begin
      if (reset) begin
         recording_ff <= 1'b0;
         len_ff       <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         silent_ff    <= '0;
      end else if (step) begin
         recording_ff <= recording_in;
         len_ff       <= len_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         silent_ff    <= silent_in;
      end
   end

   // an open frame never reaches the frame size
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < FRAME_SAMPLES)
      else $error("frame sample count reached frame size");

   // no partial frame is held while idle
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !recording_ff |-> (cnt_ff == '0) && (sum_ff == '0))
      else $error("frame accumulators not clear while idle");

   // an accepted silent frame leaves recording on
   a_silent_rec: assert property (@(posedge clock) disable iff (reset)
      step && was_silent |=> recording_ff)
      else $error("silent frame but recording stopped");

   // a start always leaves an empty record
   a_start: assert property (@(posedge clock) disable iff (reset)
      step && (op == OP_START) |=> recording_ff && (len_ff == '0) && (silent_ff == '0))
      else $error("start did not reset the record");

endmodule
`default_nettype wire

// ===== rtl/energy_vad_recorder.sv =====
// Top level of the energy voice activity recorder: handshake stages around the core.
`default_nettype none
// Energy-based voice activity detector for a recorder. Each req transfer carries one
// operation: a 16-bit sample (op 0), start (1), stop (2) or discard (3). While recording,
// sample magnitudes are summed per frame; a frame closes on frame_end or on its 480th
// sample. A closing frame that would push the record past record_capacity is dropped and
// recording stops; otherwise its samples join recorded_samples and it counts as silent
// when sum < silence_threshold * count. Every req transfer yields exactly one rsp
// transfer with the state after that item. Throughput is one item per clock while
// rsp_ready is high; each item passes the input register, then the core's state update
// loop (16 x 9 multiply plus a 25-bit compare), then the result register, which frees
// itself when taken; a new item is accepted while a result waits if the input register
// is empty. Register map (32-bit APB-style, pready always high): 0x0 silence_threshold,
// 0x4 silent_frames_needed, 0x8 record_capacity; write only while the block is idle.
module energy_vad_recorder
   import evr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_op,
   input  wire logic [SAMPLE_W-1:0]   req_sample,
   input  wire logic                  req_frame_end,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_is_recording,
   output logic                       rsp_silence_detected,
   output logic      [LEN_W-1:0]      rsp_recorded_samples,
   output logic                       rsp_frame_was_silent,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   evr_cfg_type    cfg;
   evr_result_type core_res;
   evr_result_type res_ff;

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [1:0]          in_op_ff;
   logic [SAMPLE_W-1:0] in_sample_ff;
   logic                in_frame_end_ff;

   logic                out_valid_ff, out_valid_in;
   logic                out_free;   // result register empty or emptying this cycle
   logic                advance;    // input register item moves into the core
   logic                req_xfer;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance)        out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_op_ff        <= req_op;
         in_sample_ff    <= req_sample;
         in_frame_end_ff <= req_frame_end;
      end
      if (advance) res_ff <= core_res;
   end

   evr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   evr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .op        (in_op_ff),
      .sample    (in_sample_ff),
      .frame_end (in_frame_end_ff),
      .cfg       (cfg),
      .result    (core_res)
   );

   assign rsp_valid            = out_valid_ff;
   assign rsp_is_recording     = res_ff.is_recording;
   assign rsp_silence_detected = res_ff.silence_detected;
   assign rsp_recorded_samples = res_ff.recorded_samples;
   assign rsp_frame_was_silent = res_ff.frame_was_silent;

   // an item stuck behind a full result register is kept
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff)
      else $error("input item lost while result stalled");

   // every item leaving the input register lands in the result register
   a_adv_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced item produced no result");

   // silence is only reported while recording
   a_sil_rec: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !res_ff.silence_detected || res_ff.is_recording)
      else $error("silence reported while not recording");

endmodule
`default_nettype wire
